// ===== hw/rtl/multi_channel_tick_timer_bank_core_assert.svh =====
// Assertion macros for the tick timer bank.
`ifndef MULTI_CHANNEL_TICK_TIMER_BANK_CORE_ASSERT_SVH
`define MULTI_CHANNEL_TICK_TIMER_BANK_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define MCTT_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define MCTT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MCTT_ASSERT_IMPLY(label, pre, post, msg)
`define MCTT_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== hw/rtl/mctt_pkg.sv =====
// Shared types and constants of the tick timer bank.
package mctt_pkg;

  localparam int DEF_NUM_TIMERS = 8;
  localparam int MAX_RESULTS    = 8;
  localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int CMD_W          = 3;
  localparam int ID_W           = 8;
  localparam int VAL_W          = 32;
  localparam int EXP_ID_W       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_PERIOD = 3'd1,
    CMD_SET_MODE   = 3'd2,
    CMD_SET_ENABLE = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_SET_NOTIFY = 3'd5
  } cmd_code_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  timer_id;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [EXP_ID_W-1:0] expired_id;
    logic                last;
  } exp_t;

endpackage

// ===== hw/rtl/mctt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/multi_channel_tick_timer_bank_core.sv =====
// Top level of the tick timer bank: command decode, tick sequencer and result output.
//
//   channel  dir  payload  meaning
//   cmd      in   cmd_t    one request: a tick or a command on one timer
//   exp      out  exp_t    one expiry result of a tick, last marks the final one
//
// A command other than a tick completes in the cycle it is accepted.
// A tick walks the timers in index order: for each timer, one state does the RAM
// read and the next one uses the shared increment and compare unit.
// A stalled result output holds the walk on the timer that wants to emit.
// Reset clears all timer state at once through per-timer valid bits.
`include "multi_channel_tick_timer_bank_core_assert.svh"

module multi_channel_tick_timer_bank_core #(
  parameter int NUM_TIMERS = mctt_pkg::DEF_NUM_TIMERS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  mctt_pkg::cmd_t  cmd_data,
  output logic            exp_valid,
  input  logic            exp_ready,
  output mctt_pkg::exp_t  exp_data
);

  import mctt_pkg::*;

  localparam int IDX_W = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
  localparam logic [ID_W:0] NT = (ID_W + 1)'(NUM_TIMERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EV   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [IDX_W-1:0]      idx;
  logic [RES_CNT_W-1:0]  nres;
  logic                  pend_valid;
  logic [EXP_ID_W-1:0]   pend_id;
  logic [NUM_TIMERS-1:0] count_valid, period_valid;
  logic [NUM_TIMERS-1:0] running, single_shot, notify;

  logic                  accept, id_ok, val_nz;
  logic [IDX_W-1:0]      wid;
  logic [VAL_W-1:0]      cnt_rd, per_rd, cnt, per, cnt_inc, cnt_wr;
  logic                  active, expire, emit, slot_free, stall, advance;
  logic                  push_mid, push_fin;

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign id_ok     = {1'b0, cmd_data.timer_id} < NT;
  assign wid       = cmd_data.timer_id[IDX_W-1:0];
  assign val_nz    = (cmd_data.value != '0);

  mctt_ram #(.WIDTH(VAL_W), .DEPTH(NUM_TIMERS)) u_count_ram (
    .clk   (clk),
    .we    (advance && active),
    .waddr (idx),
    .wdata (cnt_wr),
    .raddr (idx),
    .rdata (cnt_rd)
  );

  mctt_ram #(.WIDTH(VAL_W), .DEPTH(NUM_TIMERS)) u_period_ram (
    .clk   (clk),
    .we    (accept && id_ok && (cmd_data.command == CMD_SET_PERIOD)),
    .waddr (wid),
    .wdata (cmd_data.value),
    .raddr (idx),
    .rdata (per_rd)
  );

  assign cnt       = count_valid[idx] ? cnt_rd : '0;
  assign per       = period_valid[idx] ? per_rd : '0;
  assign active    = running[idx] && (per != '0);
  assign cnt_inc   = cnt + VAL_W'(1);
  assign expire    = active && (cnt_inc == per);
  assign cnt_wr    = expire ? '0 : cnt_inc;
  assign emit      = (state == ST_EV) && expire && notify[idx]
                     && (nres < RES_CNT_W'(MAX_RESULTS));
  assign slot_free = !exp_valid || exp_ready;
  assign stall     = emit && pend_valid && !slot_free;
  assign advance   = (state == ST_EV) && !stall;
  assign push_mid  = advance && emit && pend_valid;
  assign push_fin  = (state == ST_FIN) && pend_valid && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd_data.command == CMD_TICK)) begin
          state_next = ST_RD;
        end
      end
      ST_RD: state_next = ST_EV;
      ST_EV: begin
        if (advance) begin
          state_next = (idx == LAST_IDX) ? ST_FIN : ST_RD;
        end
      end
      ST_FIN: begin
        if (!pend_valid || push_fin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      nres         <= '0;
      pend_valid   <= 1'b0;
      exp_valid    <= 1'b0;
      count_valid  <= '0;
      period_valid <= '0;
      running      <= '0;
      single_shot  <= '0;
      notify       <= '0;
    end else begin
      state <= state_next;
      if (accept && (cmd_data.command == CMD_TICK)) begin
        idx  <= '0;
        nres <= '0;
      end
      if (accept && id_ok) begin
        case (cmd_data.command)
          CMD_SET_PERIOD: period_valid[wid] <= 1'b1;
          CMD_SET_MODE:   single_shot[wid]  <= val_nz;
          CMD_SET_ENABLE: begin
            running[wid]     <= val_nz;
            count_valid[wid] <= 1'b0;
          end
          CMD_CLEAR:      count_valid[wid]  <= 1'b0;
          CMD_SET_NOTIFY: notify[wid]       <= val_nz;
          default: ;
        endcase
      end
      if (advance) begin
        if (active) begin
          count_valid[idx] <= 1'b1;
        end
        if (expire && single_shot[idx]) begin
          running[idx] <= 1'b0;
        end
        if (emit) begin
          pend_valid <= 1'b1;
          nres       <= nres + RES_CNT_W'(1);
        end
        if (idx != LAST_IDX) begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (push_fin) begin
        pend_valid <= 1'b0;
      end
      if (push_mid || push_fin) begin
        exp_valid <= 1'b1;
      end else if (exp_ready) begin
        exp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      pend_id <= EXP_ID_W'(idx);
    end
    if (push_mid) begin
      exp_data.expired_id <= pend_id;
      exp_data.last       <= 1'b0;
    end else if (push_fin) begin
      exp_data.expired_id <= pend_id;
      exp_data.last       <= 1'b1;
    end
  end

  `MCTT_ASSERT_IMPLY(a_idle_no_pend, cmd_ready, !pend_valid, "Pending result left while idle.")
  `MCTT_ASSERT_IMPLY(a_nres_bound, 1'b1, nres <= RES_CNT_W'(MAX_RESULTS), "Result count over limit.")
  `MCTT_ASSERT_NEXT(a_stall_holds, stall, state == ST_EV && $stable(idx), "Stall did not hold walk.")
  `MCTT_ASSERT_NEXT(a_fin_done, state == ST_FIN && !pend_valid, state == ST_IDLE, "Tick end not idle.")

endmodule

// ===== bench/multi_channel_tick_timer_bank_core_tb.sv =====
// Self-checking testbench for the tick timer bank with a built-in expiry predictor.
module multi_channel_tick_timer_bank_core_tb;
  import mctt_pkg::*;

  localparam int NUM_TIMERS = 8;
  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 22;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd_data;
  logic exp_valid;
  logic exp_ready;
  exp_t exp_data;

  logic [VAL_W-1:0] timer_count [NUM_TIMERS];
  logic [VAL_W-1:0] timer_period [NUM_TIMERS];
  logic timer_oneshot [NUM_TIMERS];
  logic timer_running [NUM_TIMERS];
  logic timer_notify [NUM_TIMERS];

  exp_t expiry_q[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  int rx_hold_left = 0;
  int rx_stall_left = 0;
  int rx_run_left = 0;

  multi_channel_tick_timer_bank_core #(
    .NUM_TIMERS(NUM_TIMERS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data(cmd_data),
    .exp_valid(exp_valid),
    .exp_ready(exp_ready),
    .exp_data(exp_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void reset_timers();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_count[i] = '0;
      timer_period[i] = '0;
      timer_oneshot[i] = 1'b0;
      timer_running[i] = 1'b0;
      timer_notify[i] = 1'b0;
    end
  endfunction

  function automatic void predict_expiries(cmd_t c);
    exp_t fired [MAX_RESULTS];
    int n;
    int id;
    n = 0;
    id = int'(c.timer_id);
    if (c.command == CMD_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (timer_running[i] && timer_period[i] != '0) begin
          timer_count[i] = timer_count[i] + VAL_W'(1);
          if (timer_count[i] == timer_period[i]) begin
            timer_count[i] = '0;
            if (timer_oneshot[i]) timer_running[i] = 1'b0;
            if (timer_notify[i] && n < MAX_RESULTS) begin
              fired[n].expired_id = EXP_ID_W'(i);
              fired[n].last = 1'b0;
              n++;
            end
          end
        end
      end
      if (n > 0) fired[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) expiry_q.push_back(fired[k]);
    end else if (id < NUM_TIMERS) begin
      case (c.command)
        CMD_SET_PERIOD: timer_period[id] = c.value;
        CMD_SET_MODE: timer_oneshot[id] = (c.value != '0);
        CMD_SET_ENABLE: begin
          timer_running[id] = (c.value != '0);
          timer_count[id] = '0;
        end
        CMD_CLEAR: timer_count[id] = '0;
        CMD_SET_NOTIFY: timer_notify[id] = (c.value != '0);
        default: ;
      endcase
    end
  endfunction

  always @(posedge clk) begin
    exp_t want;
    if (rst) begin
      reset_timers();
      quiet_cycles = 0;
    end else begin
      if (cmd_valid && cmd_ready) predict_expiries(cmd_data);
      if (exp_valid && exp_ready) begin
        if (expiry_q.size() == 0) begin
          $error("unexpected expiry: expired_id %0d, last %0d", exp_data.expired_id,
                 exp_data.last);
          error_count++;
        end else begin
          want = expiry_q.pop_front();
          if (exp_data.expired_id !== want.expired_id) begin
            $error("expired_id: expected %0d, actual %0d", want.expired_id,
                   exp_data.expired_id);
            error_count++;
          end
          if (exp_data.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, exp_data.last);
            error_count++;
          end
        end
      end
      if ((cmd_valid && cmd_ready) || (exp_valid && exp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** multi_channel_tick_timer_bank_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    exp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        exp_ready <= 1'b0;
        rx_hold_left--;
      end else if (!idle_on) begin
        exp_ready <= 1'b1;
      end else if (rx_stall_left > 0) begin
        exp_ready <= 1'b0;
        rx_stall_left--;
      end else if (rx_run_left > 0) begin
        exp_ready <= 1'b1;
        rx_run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        exp_ready <= 1'b0;
        rx_stall_left = $urandom_range(0, 12);
      end else begin
        exp_ready <= 1'b1;
        rx_run_left = $urandom_range(0, 24);
      end
    end
  end

  function automatic cmd_t make_request(logic [CMD_W-1:0] command, logic [ID_W-1:0] timer_id,
                                        logic [VAL_W-1:0] value);
    cmd_t c;
    c.command = command;
    c.timer_id = timer_id;
    c.value = value;
    return c;
  endfunction

  // About half of the requests target real timers, mostly with small periods, so that expiries are frequent.
  function automatic cmd_t random_request();
    cmd_t c;
    int pick;
    c = make_request(CMD_TICK, ID_W'($urandom), $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) return c;
    if (pick < 50) begin
      c.command = CMD_W'($urandom_range(0, 7));
      return c;
    end
    c.timer_id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
    c.command = CMD_W'($urandom_range(int'(CMD_SET_PERIOD), int'(CMD_SET_NOTIFY)));
    case (c.command)
      CMD_SET_PERIOD: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) c.value = '0;
        else if (pick > 1) c.value = VAL_W'($urandom_range(1, 6));
      end
      CMD_CLEAR: ;
      default: begin
        pick = $urandom_range(0, 7);
        if (pick < 2) c.value = '0;
        else if (pick < 6) c.value = VAL_W'(1);
      end
    endcase
    return c;
  endfunction

  task automatic send_request(input cmd_t c);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= c;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic send(logic [CMD_W-1:0] command, logic [ID_W-1:0] timer_id,
                      logic [VAL_W-1:0] value);
    send_request(make_request(command, timer_id, value));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expiry_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send(CMD_SET_PERIOD, 8'd0, 32'd2);
    send(CMD_SET_NOTIFY, 8'd0, 32'h8000_0000);
    send(CMD_SET_ENABLE, 8'd0, 32'hFFFF_FFFF);
    send(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    send(CMD_TICK, 8'd0, 32'd0);
    send(CMD_SET_MODE, 8'd1, 32'hFFFF_FFFF);
    send(CMD_SET_PERIOD, 8'd1, 32'd1);
    send(CMD_SET_NOTIFY, 8'd1, 32'd1);
    send(CMD_SET_ENABLE, 8'd1, 32'd1);
    send(CMD_TICK, 8'd0, 32'd0);
    send(CMD_TICK, 8'd0, 32'd0);
    send(CMD_SET_PERIOD, 8'd8, 32'd1);
    send(CMD_SET_ENABLE, 8'hFF, 32'd1);
    send(CMD_RSVD_A, 8'd0, 32'd0);
    send(CMD_RSVD_B, 8'd0, 32'd1);
    send(CMD_SET_ENABLE, 8'd7, 32'd1);
    send(CMD_CLEAR, 8'd0, 32'hFFFF_FFFF);
    send(CMD_TICK, 8'd0, 32'd0);
    send(CMD_SET_PERIOD, 8'd0, 32'hFFFF_FFFF);
    send(CMD_TICK, 8'd0, 32'd0);
    send(CMD_TICK, 8'd0, 32'd0);
    send(CMD_SET_PERIOD, 8'd0, 32'd1);
    send(CMD_TICK, 8'd0, 32'd0);
    send(CMD_SET_ENABLE, 8'd0, 32'd0);
    send(CMD_TICK, 8'd0, 32'd0);
    wait_drained();
  endtask

  task automatic test_full_bank_backpressure();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      send(CMD_SET_MODE, ID_W'(i), 32'd0);
      send(CMD_SET_PERIOD, ID_W'(i), 32'd1);
      send(CMD_SET_NOTIFY, ID_W'(i), 32'd1);
      send(CMD_SET_ENABLE, ID_W'(i), 32'd1);
    end
    wait_drained();
    rx_hold_left = HOLD_CYCLES;
    repeat (10) send(CMD_TICK, ID_W'($urandom), $urandom);
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      send_request(random_request());
      if (n % 60 == 59) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_bank_backpressure();
    test_random(240);
    idle_on = 1'b0;
    test_random(30);
    if (error_count == 0) begin
      $display("** multi_channel_tick_timer_bank_core: PASSED **");
    end else begin
      $display("** multi_channel_tick_timer_bank_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mctt_pkg.sv
hw/rtl/mctt_ram.sv
hw/rtl/multi_channel_tick_timer_bank_core.sv
bench/multi_channel_tick_timer_bank_core_tb.sv
